### sv/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg
// shared types, codes and reset values of the touch gesture classifier
// ----------------------------------------------------------------------------
package tgc_pkg;

  // input item kinds carried on the slave-side tuser
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_IRQ    = 2'd1,
    ACT_REPORT = 2'd2
  } action_e;

  // raw controller event codes
  typedef enum logic [1:0] {
    EV_DOWN    = 2'd0,
    EV_UP      = 2'd1,
    EV_CONTACT = 2'd2,
    EV_NONE    = 2'd3
  } raw_ev_e;

  typedef enum logic [2:0] {
    GST_TAP      = 3'd0,
    GST_LONG_TAP = 3'd1,
    GST_UP       = 3'd2,
    GST_DOWN     = 3'd3,
    GST_RIGHT    = 3'd4,
    GST_LEFT     = 3'd5
  } gesture_e;

  localparam logic KIND_GESTURE = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // register indexes
  typedef enum logic [2:0] {
    REG_CLASSIFY_EN    = 3'd0,
    REG_NEW_EVENT_GAP  = 3'd1,
    REG_MOVE_THRESHOLD = 3'd2,
    REG_LONG_THRESHOLD = 3'd3,
    REG_PANEL_WIDTH    = 3'd4
  } reg_idx_e;

  localparam int unsigned PaddrWidth = 5;
  localparam int unsigned InDataWidth = 32;
  localparam int unsigned OutDataWidth = 80;

  localparam logic        ClassifyEnRst    = 1'b1;
  localparam logic [15:0] NewEventGapRst   = 16'd10;
  localparam logic [11:0] MoveThresholdRst = 12'd50;
  localparam logic [15:0] LongThresholdRst = 16'd100;
  localparam logic [11:0] PanelWidthRst    = 12'd320;

  localparam logic [15:0] TickMax = 16'hFFFF;

  typedef struct packed {
    logic        classify_en;
    logic [15:0] new_event_gap;
    logic [11:0] move_threshold;
    logic [15:0] long_threshold;
    logic [11:0] panel_width;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [2:0]         gesture;
    logic signed [12:0] pos_x;
    logic [11:0]        pos_y;
    logic signed [13:0] delta_x;
    logic signed [12:0] delta_y;
    logic [15:0]        gesture_ticks;
    logic [1:0]         event_code;
  } result_t;

endpackage

### sv/touch_gesture_classifier_unit.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier_unit
// classifies touch reports into taps and swipes, or passes them through
// ----------------------------------------------------------------------------
//
//   channel  | direction | payload
//   ---------+-----------+-----------------------------------------------
//   s_axis   | in        | tuser action, tdata event code and raw x/y
//   m_axis   | out       | tuser kind, tdata gesture, position, deltas
//   apb      | in/out    | five configuration registers at 4*index
//
// one item per cycle while the output register is free or drains; the classifier
// works on the item in the input register and updates the gesture state, then its
// result (if any) sits in the output register until the transfer completes.
// an item passes through the input register and then the output register, so
// both lie between the input transfer and the output transfer.
// reset clears gesture state, valid flags and loads register defaults.
// a stalled output holds back only items that reach the input register
// behind it; the input register still takes one more item meanwhile.
//
module touch_gesture_classifier_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave side
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  // [1:0] raw_ev, [13:2] raw_x, [25:14] raw_y, [31:26] zero
  input  logic [tgc_pkg::InDataWidth-1:0]     s_tdata_i,
  // [1:0] action
  input  logic [1:0]                          s_tuser_i,
  // master side
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  // [2:0] gesture, [15:3] pos_x, [27:16] pos_y, [41:28] delta_x,
  // [54:42] delta_y, [70:55] gesture_ticks, [72:71] event_code, [79:73] zero
  output logic [tgc_pkg::OutDataWidth-1:0]    m_tdata_o,
  // [0] kind
  output logic                                m_tuser_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tgc_pkg::PaddrWidth-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import tgc_pkg::*;

  cfg_t       cfg;
  logic       in_vld_q;
  logic [1:0] in_action_q;
  logic [1:0] in_event_q;
  logic [11:0] in_x_q;
  logic [11:0] in_y_q;
  logic       adv;
  logic       res_valid;
  result_t    res;
  logic       out_vld_q;
  result_t    out_q;

  tgc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the registered item moves on when the output register is free or drains
  assign adv        = in_vld_q && (!out_vld_q || m_tready_i);
  assign s_tready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_tready_o) begin
      in_vld_q <= s_tvalid_i;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_action_q <= s_tuser_i;
      in_event_q  <= s_tdata_i[1:0];
      in_x_q      <= s_tdata_i[13:2];
      in_y_q      <= s_tdata_i[25:14];
    end
  end

  tgc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .fire_i        (adv),
    .action_i      (in_action_q),
    .raw_ev_i      (in_event_q),
    .raw_x_i       (in_x_q),
    .raw_y_i       (in_y_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && res_valid) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tuser_o  = out_q.kind;
  assign m_tdata_o  = {7'd0, out_q.event_code, out_q.gesture_ticks, out_q.delta_y,
                       out_q.delta_x, out_q.pos_y, out_q.pos_x, out_q.gesture};

endmodule

### sv/tgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tgc_cfg_regs
// configuration register file behind a simple apb port
// ----------------------------------------------------------------------------
module tgc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tgc_pkg::PaddrWidth-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output tgc_pkg::cfg_t                   cfg_o
);
  import tgc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PaddrWidth-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.classify_en    <= ClassifyEnRst;
      cfg_q.new_event_gap  <= NewEventGapRst;
      cfg_q.move_threshold <= MoveThresholdRst;
      cfg_q.long_threshold <= LongThresholdRst;
      cfg_q.panel_width    <= PanelWidthRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_CLASSIFY_EN:    cfg_q.classify_en    <= pwdata[0];
        REG_NEW_EVENT_GAP:  cfg_q.new_event_gap  <= pwdata[15:0];
        REG_MOVE_THRESHOLD: cfg_q.move_threshold <= pwdata[11:0];
        REG_LONG_THRESHOLD: cfg_q.long_threshold <= pwdata[15:0];
        REG_PANEL_WIDTH:    cfg_q.panel_width    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_CLASSIFY_EN:    prdata = {31'd0, cfg_q.classify_en};
      REG_NEW_EVENT_GAP:  prdata = {16'd0, cfg_q.new_event_gap};
      REG_MOVE_THRESHOLD: prdata = {20'd0, cfg_q.move_threshold};
      REG_LONG_THRESHOLD: prdata = {16'd0, cfg_q.long_threshold};
      REG_PANEL_WIDTH:    prdata = {20'd0, cfg_q.panel_width};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### sv/tgc_core.sv
// ----------------------------------------------------------------------------
// tgc_core
// gesture state and single-pass classification of one registered item
// ----------------------------------------------------------------------------
module tgc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tgc_pkg::cfg_t    cfg_i,
  input  logic             fire_i,
  input  logic [1:0]       action_i,
  input  logic [1:0]       raw_ev_i,
  input  logic [11:0]      raw_x_i,
  input  logic [11:0]      raw_y_i,
  output logic             res_valid_o,
  output tgc_pkg::result_t res_o
);
  import tgc_pkg::*;

  logic               watching_q, watching_d;
  logic               captured_q, captured_d;
  logic [15:0]        ticks_q, ticks_d;
  logic signed [12:0] first_x_q, first_x_d;
  logic [11:0]        first_y_q, first_y_d;

  action_e            act;
  raw_ev_e            ev;
  logic signed [12:0] x;
  logic signed [13:0] dx;
  logic signed [12:0] dy;
  logic [13:0]        dx_neg;
  logic [12:0]        dy_neg;
  logic [12:0]        ax;
  logic [11:0]        ay;
  logic               tap_zone;
  gesture_e           gst;

  assign act = action_e'(action_i);
  assign ev  = raw_ev_e'(raw_ev_i);

  // mirrored x and displacements from the first touch
  assign x      = $signed({1'b0, cfg_i.panel_width}) - $signed({1'b0, raw_x_i});
  assign dx     = $signed({x[12], x}) - $signed({first_x_q[12], first_x_q});
  assign dy     = $signed({1'b0, raw_y_i}) - $signed({1'b0, first_y_q});
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign ax     = dx[13] ? dx_neg[12:0] : dx[12:0];
  assign ay     = dy[12] ? dy_neg[11:0] : dy[11:0];

  assign tap_zone = (ax < {1'b0, cfg_i.move_threshold}) && (ay < cfg_i.move_threshold);

  always_comb begin
    if (tap_zone) begin
      gst = (ticks_q < cfg_i.long_threshold) ? GST_TAP : GST_LONG_TAP;
    end else if ({1'b0, ay} < ax) begin
      gst = dx[13] ? GST_LEFT : GST_RIGHT;
    end else begin
      gst = dy[12] ? GST_UP : GST_DOWN;
    end
  end

  always_comb begin
    watching_d  = watching_q;
    captured_d  = captured_q;
    ticks_d     = ticks_q;
    first_x_d   = first_x_q;
    first_y_d   = first_y_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (act)
      ACT_TICK: begin
        if (ticks_q != TickMax) begin
          ticks_d = ticks_q + 16'd1;
        end
      end
      ACT_IRQ: begin
        if (cfg_i.classify_en && !watching_q && (ticks_q > cfg_i.new_event_gap)) begin
          watching_d = 1'b1;
          captured_d = 1'b0;
          ticks_d    = '0;
        end
      end
      ACT_REPORT: begin
        if (!cfg_i.classify_en) begin
          // simple mode: pass the decoded report straight through
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_REPORT;
          res_o.pos_x      = x;
          res_o.pos_y      = raw_y_i;
          res_o.event_code = raw_ev_i;
        end else if (watching_q) begin
          if ((ev == EV_DOWN) && !captured_q) begin
            first_x_d  = x;
            first_y_d  = raw_y_i;
            captured_d = 1'b1;
          end
          if (ev == EV_UP) begin
            watching_d          = 1'b0;
            res_valid_o         = 1'b1;
            res_o.kind          = KIND_GESTURE;
            res_o.gesture       = gst;
            res_o.pos_x         = first_x_q;
            res_o.pos_y         = first_y_q;
            res_o.delta_x       = dx;
            res_o.delta_y       = dy;
            res_o.gesture_ticks = ticks_q;
            res_o.event_code    = EV_UP;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watching_q <= 1'b0;
      captured_q <= 1'b0;
      ticks_q    <= '0;
      first_x_q  <= '0;
      first_y_q  <= '0;
    end else if (fire_i) begin
      watching_q <= watching_d;
      captured_q <= captured_d;
      ticks_q    <= ticks_d;
      first_x_q  <= first_x_d;
      first_y_q  <= first_y_d;
    end
  end

endmodule

### sv/tgc_checker.sv
// ----------------------------------------------------------------------------
// tgc_checker
// port-level checks on the gesture classifier, bound to the top level
// ----------------------------------------------------------------------------
module tgc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_tvalid_o,
  input logic                             m_tready_i,
  input logic [tgc_pkg::OutDataWidth-1:0] m_tdata_o,
  input logic                             m_tuser_o,
  input logic                             pready
);
  import tgc_pkg::*;

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("result changed while stalled");

  // pass-through reports carry no gesture, deltas or duration
  a_report_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o == KIND_REPORT) |->
      (m_tdata_o[2:0] == GST_TAP) && (m_tdata_o[70:28] == '0))
    else $error("report result carries gesture fields");

  // completed gestures end on lift-up and use a defined gesture code
  a_gesture_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o == KIND_GESTURE) |->
      (m_tdata_o[72:71] == EV_UP) && (m_tdata_o[2:0] <= GST_LEFT))
    else $error("malformed gesture result");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o),
  .pready     (pready)
);
